@@ rtl/core/bpt_pkg.sv @@
// Shared types, constants and helper functions of the Bezier pose pipeline.
package bpt_pkg;

  // Port field widths.
  localparam int CoordW = 24;
  localparam int AngW   = 16;
  localparam int ParamW = 17;
  localparam int HeadW  = 16;
  localparam int CfgW   = 24;

  // Internal widths: coordinates in Q.32 inches, heading vector, angle accumulator.
  localparam int PosW  = 44;
  localparam int VecW  = 48;
  localparam int ZW    = 26;
  localparam int ProdW = PosW + ParamW + 1;
  localparam int DegProdW = ZW + 28;

  localparam int AtanLen = 24;
  localparam int CordicStagesDefault = 16;

  localparam logic [CfgW-1:0]        CfgReset    = 24'd786432;
  localparam logic [29:0]            GainQ30     = 30'd652032874;
  localparam logic signed [27:0]     DegToRadQ35 = 28'sd74961321;
  localparam logic signed [ZW-1:0]   Deg180Q16   = 26'sd11796480;
  localparam logic [ParamW-1:0]      ParamOne    = 17'd65536;
  localparam int QuarterTurn = 5760;
  localparam int HalfTurn    = 11520;
  localparam int TwoTurns    = 46080;
  localparam int NormBits    = 40;
  localparam logic signed [HeadW-1:0]  HeadingMax = 16'sd25736;
  localparam logic signed [CoordW-1:0] PtMax      = 24'sd8388607;
  localparam logic signed [CoordW-1:0] PtMin      = -24'sd8388608;

  // Quadrant codes of a reduced angle.
  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;
  localparam logic [1:0] QuadFourth = 2'd3;

  // Arctangent of 2^-i in degrees Q.16.
  localparam logic signed [ZW-1:0] AtanDeg [AtanLen] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } xy_t;

  typedef struct packed {
    xy_t               s;
    xy_t               e;
    logic [ParamW-1:0] t;
    logic [1:0]        quad_s;
    logic [1:0]        quad_e;
  } seg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pt_t;

  typedef struct packed {
    logic [1:0]            quad;
    logic signed [ZW-1:0]  z;
  } rot_ang_t;

  // Reduce an angle (degrees * 64) to a quadrant and a residual angle in degrees Q.16.
  function automatic rot_ang_t reduce_angle(input logic signed [17:0] ang);
    logic [17:0] v;
    logic [3:0]  q4;
    logic [17:0] r;
    rot_ang_t    res;
    v  = unsigned'(ang) + 18'(TwoTurns);
    q4 = '0;
    for (int k = 1; k < 16; k++) begin
      if (v >= 18'(k * QuarterTurn)) q4 = q4 + 4'd1;
    end
    r = v - 18'(q4) * 18'(QuarterTurn);
    res.quad = q4[1:0];
    res.z    = {3'b000, r[12:0], 10'b0};
    return res;
  endfunction

endpackage

@@ rtl/core/bezier_pose_from_tangents.sv @@
// Top level of the Bezier pose pipeline: input stage, configuration register and datapath.
//
// Usage: a request is taken at a rising edge with start high and busy low; busy is
// always low, so one request can be issued in every cycle. Each request carries the
// segment end points, the two tangent angles and the curve parameter.
// The result (point_x_o, point_y_o, heading_o) passes the input stage, the rotation
// CORDIC, the Bezier unit and the heading unit, and is marked by done_o for exactly one
// cycle. Throughput is one result per cycle, set by the fully pipelined rotation
// CORDIC, de Casteljau levels and vectoring CORDIC. Results leave in request order.
// The receiver cannot stall; it must take each result in the cycle done_o is high.
// control_distance is written through cfg_we_i / cfg_wdata_i and should only change
// while no request is in flight. Reset clears all valid bits, so no result appears
// until a new request, and loads control_distance with 12.0 inches.
module bezier_pose_from_tangents #(
  parameter int CORDIC_STAGES = bpt_pkg::CordicStagesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cfg_we_i,
  input  logic [bpt_pkg::CfgW-1:0]             cfg_wdata_i,
  input  logic signed [bpt_pkg::CoordW-1:0]    start_x_i,
  input  logic signed [bpt_pkg::CoordW-1:0]    start_y_i,
  input  logic signed [bpt_pkg::CoordW-1:0]    end_x_i,
  input  logic signed [bpt_pkg::CoordW-1:0]    end_y_i,
  input  logic signed [bpt_pkg::AngW-1:0]      start_angle_i,
  input  logic signed [bpt_pkg::AngW-1:0]      end_angle_i,
  input  logic [bpt_pkg::ParamW-1:0]           curve_param_i,
  output logic                                 done_o,
  output logic signed [bpt_pkg::CoordW-1:0]    point_x_o,
  output logic signed [bpt_pkg::CoordW-1:0]    point_y_o,
  output logic signed [bpt_pkg::HeadW-1:0]     heading_o
);

  localparam int PosW = bpt_pkg::PosW;

  // Configuration register.
  logic [bpt_pkg::CfgW-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bpt_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Input stage: angle reduction, parameter clamp and scaled control distance.
  bpt_pkg::rot_ang_t ang_s, ang_e;
  logic [53:0]       gain_prod;
  logic              in_vld_q;
  bpt_pkg::seg_t     in_seg_q;
  logic signed [PosW-1:0]        x0_q;
  logic signed [bpt_pkg::ZW-1:0] zs_q, ze_q;

  always_comb begin
    ang_s     = bpt_pkg::reduce_angle(18'(start_angle_i));
    ang_e     = bpt_pkg::reduce_angle(18'(end_angle_i) + 18'(bpt_pkg::HalfTurn));
    gain_prod = 54'(cfg_q) * 54'(bpt_pkg::GainQ30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_seg_q.s.x   <= {{(PosW-40){start_x_i[bpt_pkg::CoordW-1]}}, start_x_i, 16'b0};
    in_seg_q.s.y   <= {{(PosW-40){start_y_i[bpt_pkg::CoordW-1]}}, start_y_i, 16'b0};
    in_seg_q.e.x   <= {{(PosW-40){end_x_i[bpt_pkg::CoordW-1]}}, end_x_i, 16'b0};
    in_seg_q.e.y   <= {{(PosW-40){end_y_i[bpt_pkg::CoordW-1]}}, end_y_i, 16'b0};
    in_seg_q.t     <= (curve_param_i > bpt_pkg::ParamOne) ? bpt_pkg::ParamOne : curve_param_i;
    in_seg_q.quad_s <= ang_s.quad;
    in_seg_q.quad_e <= ang_e.quad;
    zs_q           <= ang_s.z;
    ze_q           <= ang_e.z;
    x0_q           <= {{(PosW-40){1'b0}}, gain_prod[53:14]};
  end

  logic          rot_vld;
  bpt_pkg::seg_t rot_seg;
  bpt_pkg::xy_t  rot_s, rot_e;

  bpt_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
    .clk_i, .rst_ni, .valid_i(in_vld_q), .seg_i(in_seg_q), .x0_i(x0_q),
    .zs_i(zs_q), .ze_i(ze_q),
    .valid_o(rot_vld), .seg_o(rot_seg), .rot_s_o(rot_s), .rot_e_o(rot_e)
  );

  logic          bez_vld;
  bpt_pkg::xy_t  bez_tan;
  bpt_pkg::pt_t  bez_pt;

  bpt_bezier u_bez (
    .clk_i, .rst_ni, .valid_i(rot_vld), .seg_i(rot_seg), .rot_s_i(rot_s), .rot_e_i(rot_e),
    .valid_o(bez_vld), .tan_o(bez_tan), .pt_o(bez_pt)
  );

  bpt_pkg::pt_t out_pt;

  bpt_heading #(.STAGES(CORDIC_STAGES)) u_head (
    .clk_i, .rst_ni, .valid_i(bez_vld), .tan_i(bez_tan), .pt_i(bez_pt),
    .valid_o(done_o), .heading_o(heading_o), .pt_o(out_pt)
  );

  assign point_x_o = out_pt.x;
  assign point_y_o = out_pt.y;

endmodule

@@ rtl/core/bpt_rot_cordic.sv @@
// Two-lane pipelined rotation CORDIC giving the start and end tangent offsets.
module bpt_rot_cordic #(
  parameter int STAGES = bpt_pkg::CordicStagesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  bpt_pkg::seg_t                  seg_i,
  input  logic signed [bpt_pkg::PosW-1:0] x0_i,
  input  logic signed [bpt_pkg::ZW-1:0]   zs_i,
  input  logic signed [bpt_pkg::ZW-1:0]   ze_i,
  output logic                           valid_o,
  output bpt_pkg::seg_t                  seg_o,
  output bpt_pkg::xy_t                   rot_s_o,
  output bpt_pkg::xy_t                   rot_e_o
);

  logic signed [bpt_pkg::PosW-1:0] xs_q [STAGES+1];
  logic signed [bpt_pkg::PosW-1:0] ys_q [STAGES+1];
  logic signed [bpt_pkg::PosW-1:0] xe_q [STAGES+1];
  logic signed [bpt_pkg::PosW-1:0] ye_q [STAGES+1];
  logic signed [bpt_pkg::ZW-1:0]   zs_q [STAGES+1];
  logic signed [bpt_pkg::ZW-1:0]   ze_q [STAGES+1];
  bpt_pkg::seg_t                   seg_q [STAGES+1];
  logic [STAGES:0]                 vld_q;

  // Valid bits travel alongside the micro-rotations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-1:0], valid_i};
    end
  end

  // One micro-rotation per stage, both lanes in parallel.
  always_ff @(posedge clk_i) begin
    xs_q[0]  <= x0_i;
    ys_q[0]  <= '0;
    xe_q[0]  <= x0_i;
    ye_q[0]  <= '0;
    zs_q[0]  <= zs_i;
    ze_q[0]  <= ze_i;
    seg_q[0] <= seg_i;
    for (int i = 0; i < STAGES; i++) begin
      seg_q[i+1] <= seg_q[i];
      if (zs_q[i] >= 0) begin
        xs_q[i+1] <= xs_q[i] - (ys_q[i] >>> i);
        ys_q[i+1] <= ys_q[i] + (xs_q[i] >>> i);
        zs_q[i+1] <= zs_q[i] - bpt_pkg::AtanDeg[i];
      end else begin
        xs_q[i+1] <= xs_q[i] + (ys_q[i] >>> i);
        ys_q[i+1] <= ys_q[i] - (xs_q[i] >>> i);
        zs_q[i+1] <= zs_q[i] + bpt_pkg::AtanDeg[i];
      end
      if (ze_q[i] >= 0) begin
        xe_q[i+1] <= xe_q[i] - (ye_q[i] >>> i);
        ye_q[i+1] <= ye_q[i] + (xe_q[i] >>> i);
        ze_q[i+1] <= ze_q[i] - bpt_pkg::AtanDeg[i];
      end else begin
        xe_q[i+1] <= xe_q[i] + (ye_q[i] >>> i);
        ye_q[i+1] <= ye_q[i] - (xe_q[i] >>> i);
        ze_q[i+1] <= ze_q[i] + bpt_pkg::AtanDeg[i];
      end
    end
  end

  // The x lane is the cosine, the y lane the sine.
  assign valid_o   = vld_q[STAGES];
  assign seg_o     = seg_q[STAGES];
  assign rot_s_o.x = xs_q[STAGES];
  assign rot_s_o.y = ys_q[STAGES];
  assign rot_e_o.x = xe_q[STAGES];
  assign rot_e_o.y = ye_q[STAGES];

endmodule

@@ rtl/core/bpt_lerp_level.sv @@
// One de Casteljau level: N linear interpolations in difference, multiply and add stages.
module bpt_lerp_level #(
  parameter int N = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  bpt_pkg::xy_t [N:0]              pts_i,
  input  logic [bpt_pkg::ParamW-1:0]      t_i,
  output logic                            valid_o,
  output logic [bpt_pkg::ParamW-1:0]      t_o,
  output bpt_pkg::xy_t [N-1:0]            pts_o,
  output bpt_pkg::xy_t [N-1:0]            diff_o
);

  logic [2:0]                        vld_q;
  bpt_pkg::xy_t [N-1:0]              a_d_q, d_d_q, a_m_q, d_m_q, out_q, diff_q;
  logic [bpt_pkg::ParamW-1:0]        t_d_q, t_m_q, t_a_q;
  logic signed [bpt_pkg::ProdW-1:0]  mx_q [N];
  logic signed [bpt_pkg::ProdW-1:0]  my_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // Differences of neighboring points.
    for (int k = 0; k < N; k++) begin
      a_d_q[k]   <= pts_i[k];
      d_d_q[k].x <= pts_i[k+1].x - pts_i[k].x;
      d_d_q[k].y <= pts_i[k+1].y - pts_i[k].y;
    end
    t_d_q <= t_i;
    // Scale each difference by t.
    for (int k = 0; k < N; k++) begin
      mx_q[k] <= d_d_q[k].x * $signed({1'b0, t_d_q});
      my_q[k] <= d_d_q[k].y * $signed({1'b0, t_d_q});
    end
    a_m_q <= a_d_q;
    d_m_q <= d_d_q;
    t_m_q <= t_d_q;
    // Add the floored scaled difference back onto the first point.
    for (int k = 0; k < N; k++) begin
      out_q[k].x <= a_m_q[k].x + bpt_pkg::PosW'(mx_q[k] >>> 16);
      out_q[k].y <= a_m_q[k].y + bpt_pkg::PosW'(my_q[k] >>> 16);
    end
    diff_q <= d_m_q;
    t_a_q  <= t_m_q;
  end

  assign valid_o = vld_q[2];
  assign t_o     = t_a_q;
  assign pts_o   = out_q;
  assign diff_o  = diff_q;

endmodule

@@ rtl/core/bpt_bezier.sv @@
// Control point placement, three de Casteljau levels and point rounding with saturation.
module bpt_bezier (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bpt_pkg::seg_t  seg_i,
  input  bpt_pkg::xy_t   rot_s_i,
  input  bpt_pkg::xy_t   rot_e_i,
  output logic           valid_o,
  output bpt_pkg::xy_t   tan_o,
  output bpt_pkg::pt_t   pt_o
);

  // Map the cosine and sine of the residual angle to an (x, y) offset per quadrant.
  function automatic bpt_pkg::xy_t tan_off(input logic [1:0] q, input bpt_pkg::xy_t r);
    bpt_pkg::xy_t o;
    unique case (q)
      bpt_pkg::QuadFirst:  begin o.x = r.y;  o.y = r.x;  end
      bpt_pkg::QuadSecond: begin o.x = r.x;  o.y = -r.y; end
      bpt_pkg::QuadThird:  begin o.x = -r.y; o.y = -r.x; end
      bpt_pkg::QuadFourth: begin o.x = -r.x; o.y = r.y;  end
    endcase
    return o;
  endfunction

  // Round Q.32 to Q8.16, half up, and clamp to the port range.
  function automatic logic signed [bpt_pkg::CoordW-1:0] sat_pt(
    input logic signed [bpt_pkg::PosW-1:0] v
  );
    logic signed [bpt_pkg::PosW-1:0] r;
    r = (v + 44'sd32768) >>> 16;
    if (r > bpt_pkg::PosW'(bpt_pkg::PtMax)) return bpt_pkg::PtMax;
    if (r < bpt_pkg::PosW'(bpt_pkg::PtMin)) return bpt_pkg::PtMin;
    return r[bpt_pkg::CoordW-1:0];
  endfunction

  logic                        c_vld_q;
  bpt_pkg::xy_t [3:0]          c_pts_q;
  logic [bpt_pkg::ParamW-1:0]  c_t_q;
  bpt_pkg::xy_t                off_s, off_e;

  always_comb begin
    off_s = tan_off(seg_i.quad_s, rot_s_i);
    off_e = tan_off(seg_i.quad_e, rot_e_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= valid_i;
    end
  end

  // Control polygon: start, start plus offset, end plus offset, end.
  always_ff @(posedge clk_i) begin
    c_pts_q[0]   <= seg_i.s;
    c_pts_q[1].x <= seg_i.s.x + off_s.x;
    c_pts_q[1].y <= seg_i.s.y + off_s.y;
    c_pts_q[2].x <= seg_i.e.x + off_e.x;
    c_pts_q[2].y <= seg_i.e.y + off_e.y;
    c_pts_q[3]   <= seg_i.e;
    c_t_q        <= seg_i.t;
  end

  logic                        l1_vld, l2_vld, l3_vld;
  logic [bpt_pkg::ParamW-1:0]  l1_t, l2_t, l3_t;
  bpt_pkg::xy_t [2:0]          l1_pts, l1_diff;
  bpt_pkg::xy_t [1:0]          l2_pts, l2_diff;
  bpt_pkg::xy_t [0:0]          l3_pts, l3_diff;

  bpt_lerp_level #(.N(3)) u_l1 (
    .clk_i, .rst_ni, .valid_i(c_vld_q), .pts_i(c_pts_q), .t_i(c_t_q),
    .valid_o(l1_vld), .t_o(l1_t), .pts_o(l1_pts), .diff_o(l1_diff)
  );

  bpt_lerp_level #(.N(2)) u_l2 (
    .clk_i, .rst_ni, .valid_i(l1_vld), .pts_i(l1_pts), .t_i(l1_t),
    .valid_o(l2_vld), .t_o(l2_t), .pts_o(l2_pts), .diff_o(l2_diff)
  );

  // The last difference is the tangent used for the heading.
  bpt_lerp_level #(.N(1)) u_l3 (
    .clk_i, .rst_ni, .valid_i(l2_vld), .pts_i(l2_pts), .t_i(l2_t),
    .valid_o(l3_vld), .t_o(l3_t), .pts_o(l3_pts), .diff_o(l3_diff)
  );

  logic          s_vld_q;
  bpt_pkg::xy_t  s_tan_q;
  bpt_pkg::pt_t  s_pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= l3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s_tan_q  <= l3_diff[0];
    s_pt_q.x <= sat_pt(l3_pts[0].x);
    s_pt_q.y <= sat_pt(l3_pts[0].y);
  end

  assign valid_o = s_vld_q;
  assign tan_o   = s_tan_q;
  assign pt_o    = s_pt_q;

endmodule

@@ rtl/core/bpt_heading.sv @@
// Heading unit: normalization, vectoring CORDIC and degree to radian conversion.
module bpt_heading #(
  parameter int STAGES = bpt_pkg::CordicStagesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  bpt_pkg::xy_t                        tan_i,
  input  bpt_pkg::pt_t                        pt_i,
  output logic                                valid_o,
  output logic signed [bpt_pkg::HeadW-1:0]    heading_o,
  output bpt_pkg::pt_t                        pt_o
);

  localparam int VecW = bpt_pkg::VecW;
  localparam int ZW   = bpt_pkg::ZW;
  localparam int Lat  = STAGES + 6;

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // Fold the vector into the right half plane and record the base angle.
  logic signed [VecW-1:0] tx, ty, re0, im0;
  logic signed [ZW-1:0]   base0;
  logic [VecW-1:0]        mag_or0;

  always_comb begin
    tx = {{(VecW-bpt_pkg::PosW){tan_i.x[bpt_pkg::PosW-1]}}, tan_i.x};
    ty = {{(VecW-bpt_pkg::PosW){tan_i.y[bpt_pkg::PosW-1]}}, tan_i.y};
    if (ty < 0) begin
      re0   = -ty;
      im0   = -tx;
      base0 = (tx >= 0) ? bpt_pkg::Deg180Q16 : -bpt_pkg::Deg180Q16;
    end else begin
      re0   = ty;
      im0   = tx;
      base0 = '0;
    end
    mag_or0 = unsigned'(re0) | unsigned'(im0[VecW-1] ? -im0 : im0);
  end

  logic signed [VecW-1:0] n_re_q, n_im_q, s_re_q, s_im_q;
  logic signed [ZW-1:0]   n_base_q, s_base_q;
  logic                   n_zero_q, s_zero_q;
  logic [VecW-1:0]        n_or_q;
  bpt_pkg::pt_t           n_pt_q, s_pt_q;
  logic [5:0]             s_shift_q;
  logic [5:0]             blen;
  logic [5:0]             shift;

  // Doubling count that brings the larger magnitude to at least 2^40.
  always_comb begin
    blen = '0;
    for (int i = 0; i < VecW; i++) begin
      if (n_or_q[i]) blen = 6'(i + 1);
    end
    shift = (blen <= 6'(bpt_pkg::NormBits)) ? 6'(bpt_pkg::NormBits + 1) - blen : '0;
  end

  logic signed [VecW-1:0] re_q   [STAGES+1];
  logic signed [VecW-1:0] im_q   [STAGES+1];
  logic signed [ZW-1:0]   z_q    [STAGES+1];
  logic signed [ZW-1:0]   base_q [STAGES+1];
  logic                   zero_q [STAGES+1];
  bpt_pkg::pt_t           pt_q   [STAGES+1];

  logic signed [ZW-1:0]                 deg_q;
  logic                                 d_zero_q, m_zero_q;
  bpt_pkg::pt_t                         d_pt_q, m_pt_q, out_pt_q;
  logic signed [bpt_pkg::DegProdW-1:0]  prod_q;
  logic signed [bpt_pkg::DegProdW-1:0]  rad;
  logic signed [bpt_pkg::HeadW-1:0]     heading_q;

  always_comb begin
    rad = (prod_q + 54'sd17179869184) >>> 35;
  end

  always_ff @(posedge clk_i) begin
    // Fold stage.
    n_re_q   <= re0;
    n_im_q   <= im0;
    n_base_q <= base0;
    n_zero_q <= (tx == 0) && (ty == 0);
    n_or_q   <= mag_or0;
    n_pt_q   <= pt_i;
    // Leading-one search stage.
    s_re_q    <= n_re_q;
    s_im_q    <= n_im_q;
    s_base_q  <= n_base_q;
    s_zero_q  <= n_zero_q;
    s_shift_q <= shift;
    s_pt_q    <= n_pt_q;
    // Normalizing shift stage.
    re_q[0]   <= s_re_q <<< s_shift_q;
    im_q[0]   <= s_im_q <<< s_shift_q;
    z_q[0]    <= '0;
    base_q[0] <= s_base_q;
    zero_q[0] <= s_zero_q;
    pt_q[0]   <= s_pt_q;
    // Vectoring micro-rotations drive the imaginary part toward zero.
    for (int i = 0; i < STAGES; i++) begin
      base_q[i+1] <= base_q[i];
      zero_q[i+1] <= zero_q[i];
      pt_q[i+1]   <= pt_q[i];
      if (im_q[i] > 0) begin
        re_q[i+1] <= re_q[i] + (im_q[i] >>> i);
        im_q[i+1] <= im_q[i] - (re_q[i] >>> i);
        z_q[i+1]  <= z_q[i] + bpt_pkg::AtanDeg[i];
      end else begin
        re_q[i+1] <= re_q[i] - (im_q[i] >>> i);
        im_q[i+1] <= im_q[i] + (re_q[i] >>> i);
        z_q[i+1]  <= z_q[i] - bpt_pkg::AtanDeg[i];
      end
    end
    // Angle in degrees, then scaled to radians.
    deg_q    <= base_q[STAGES] + z_q[STAGES];
    d_zero_q <= zero_q[STAGES];
    d_pt_q   <= pt_q[STAGES];
    prod_q   <= deg_q * bpt_pkg::DegToRadQ35;
    m_zero_q <= d_zero_q;
    m_pt_q   <= d_pt_q;
    // Round, clamp and force zero for a null tangent.
    out_pt_q <= m_pt_q;
    if (m_zero_q) begin
      heading_q <= '0;
    end else if (rad > bpt_pkg::DegProdW'(bpt_pkg::HeadingMax)) begin
      heading_q <= bpt_pkg::HeadingMax;
    end else if (rad < -bpt_pkg::DegProdW'(bpt_pkg::HeadingMax)) begin
      heading_q <= -bpt_pkg::HeadingMax;
    end else begin
      heading_q <= rad[bpt_pkg::HeadW-1:0];
    end
  end

  assign valid_o   = vld_q[Lat-1];
  assign heading_o = heading_q;
  assign pt_o      = out_pt_q;

endmodule

@@ rtl/core/bpt_checker.sv @@
// Port-level checks of the Bezier pose pipeline and their attachment to the top level.
module bpt_checker #(
  parameter int CORDIC_STAGES = bpt_pkg::CordicStagesDefault
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic signed [bpt_pkg::HeadW-1:0]     heading_o
);

  localparam int Lat = 19 + 2 * CORDIC_STAGES;

  // Every request yields exactly one result strobe, and no strobe appears without a request.
  // Cycles before the start of the run count as having no request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == ($past(start && !busy && rst_ni, Lat) === 1'b1))
    else $error("result strobe does not match a request issued %0d cycles earlier", Lat);

  // The pipeline never refuses a request.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // The heading stays within plus or minus pi.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_o <= bpt_pkg::HeadingMax) && (heading_o >= -bpt_pkg::HeadingMax))
    else $error("heading out of range");

endmodule

bind bezier_pose_from_tangents bpt_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_bpt_checker (.*);
